// File: rtl/core/mbtcp_pkg.sv
`timescale 1ns / 1ps
package mbtcp_pkg;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
   } req_payload_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] transaction_id;
      logic [7:0]  unit_addr;
      logic [7:0]  function_code;
      logic [15:0] start_item;
      logic [15:0] item_count;
      logic [7:0]  byte_count;
      logic [15:0] value_word;
      logic [2:0]  status;
      logic        last;
   } rsp_payload_type;

   // one classified byte event from the parser: up to two results
   typedef struct packed {
      logic            two;
      rsp_payload_type first;
      rsp_payload_type second;
   } evt_type;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_PROTOCOL = 3'd1;
   localparam logic [2:0] ST_ADDRESS  = 3'd2;
   localparam logic [2:0] ST_LENGTH   = 3'd3;
   localparam logic [2:0] ST_ITEMS    = 3'd4;
   localparam logic [2:0] ST_BYTES    = 3'd5;
   localparam logic [2:0] ST_FUNCTION = 3'd6;

   localparam logic [1:0] CSR_PROTOCOL = 2'd0;
   localparam logic [1:0] CSR_MIN_UNIT = 2'd1;
   localparam logic [1:0] CSR_MAX_UNIT = 2'd2;
   localparam logic [1:0] CSR_MAX_PDU  = 2'd3;

   localparam int unsigned EVT_W = $bits(evt_type);

endpackage

// File: rtl/core/modbus_tcp_request_parser.sv
`timescale 1ns / 1ps
// channel | ports          | direction | handshake
// request | req_*          | in        | valid / stall
// result  | rsp_*          | out       | valid / stall
// csr     | csr_*          | in        | valid / ready
// One request byte per cycle while req_stall is low; a byte yields zero, one or two results.
// The last data word of a multiple write gives two results: the data word, then a final result with last set.
// Reset is synchronous and returns all registers but the queue storage to their reset values.
// req_stall rises when the four-entry event queue holds three events; the byte parser
// and the result drain stall independently.
module modbus_tcp_request_parser
   import mbtcp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [1:0]      csr_index,
   input  logic [15:0]     csr_data
);

   logic [15:0] prot_ff;
   logic [7:0]  minu_ff, maxu_ff;
   logic [8:0]  maxp_ff;
   logic        in_fire, ev_valid, q_full, q_empty, q_pop;
   evt_type     ev, q_data;

   assign csr_ready = 1'b1;
   assign req_stall = q_full;
   assign in_fire   = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         prot_ff <= '0; minu_ff <= 8'd1; maxu_ff <= 8'd247; maxp_ff <= 9'd253;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PROTOCOL: prot_ff <= csr_data;
            CSR_MIN_UNIT: minu_ff <= csr_data[7:0];
            CSR_MAX_UNIT: maxu_ff <= csr_data[7:0];
            CSR_MAX_PDU:  maxp_ff <= csr_data[8:0];
         endcase
      end
   end

   mbtcp_front u_front (
      .clock, .reset, .in_fire, .in_data(req_data),
      .protocol_ident(prot_ff), .min_unit_addr(minu_ff), .max_unit_addr(maxu_ff),
      .max_pdu_bytes(maxp_ff), .evt_valid(ev_valid), .evt(ev)
   );

   mbtcp_queue u_queue (
      .clock, .reset, .wr_en(ev_valid), .wr_data(ev), .full(q_full), .empty(q_empty),
      .rd_en(q_pop), .rd_data(q_data)
   );

   mbtcp_back u_back (
      .clock, .reset, .q_empty, .q_data, .q_pop, .rsp_valid, .rsp_stall, .rsp_data
   );

`ifndef NO_ASSERTIONS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !ev_valid) else $error("event pushed into full queue");
   a_pop_only_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (rsp_valid && !rsp_stall)) else $error("pop without delivery");
   a_data_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == 1'b0) |-> !rsp_data.last)
      else $error("data word marked last");
`endif

endmodule

// File: rtl/core/mbtcp_front.sv
`timescale 1ns / 1ps
module mbtcp_front
   import mbtcp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_fire,
   input  req_payload_type in_data,
   input  logic [15:0]     protocol_ident,
   input  logic [7:0]      min_unit_addr,
   input  logic [7:0]      max_unit_addr,
   input  logic [8:0]      max_pdu_bytes,
   output logic            evt_valid,
   output evt_type         evt
);

   logic [8:0]  pos_ff, pos_in;
   logic        idle_ff, idle_in;
   logic [15:0] trn_ff, trn_in, len_ff, len_in, start_ff, start_in, cnt_ff, cnt_in;
   logic [7:0]  unit_ff, unit_in, func_ff, func_in, bytes_ff, bytes_in, hold_ff, hold_in;

   always_comb begin
      logic [7:0]  b;
      logic [8:0]  pos;
      logic        idle;
      logic [15:0] trn, len, st, cnt, n16;
      logic [7:0]  unit, func, bytes, hold;
      logic [17:0] pdu;
      rsp_payload_type r;
      b = in_data.rx_byte;
      pos = pos_ff; idle = idle_ff; trn = trn_ff; len = len_ff; st = start_ff;
      cnt = cnt_ff; unit = unit_ff; func = func_ff; bytes = bytes_ff; hold = hold_ff;
      evt_valid = 1'b0;
      evt = '0;
      pdu = '0;
      n16 = '0;
      r = '0;
      if (in_data.frame_start) begin
         pos = '0; idle = 1'b0; trn = '0; len = '0; st = '0; cnt = '0;
         unit = '0; func = '0; bytes = '0; hold = '0;
      end
      pos_in = pos;
      if (!idle) begin
         if (pos != 9'h1FF) pos_in = pos + 9'd1;
         r.kind = 1'b1;
         r.last = 1'b1;
         unique case (pos)
            9'd0, 9'd1: trn = {trn[7:0], b};
            9'd2:       hold = b;
            9'd3: if ({hold, b} != protocol_ident) begin
               evt_valid = 1'b1; r.status = ST_PROTOCOL; idle = 1'b1;
            end
            9'd4, 9'd5: len = {len[7:0], b};
            9'd6: begin
               unit = b;
               if (b < min_unit_addr || b > max_unit_addr) begin
                  evt_valid = 1'b1; r.status = ST_ADDRESS; idle = 1'b1;
               end
            end
            9'd7: begin
               func = b;
               if (!((b >= 8'd1 && b <= 8'd6) || b == 8'd16)) begin
                  evt_valid = 1'b1; r.status = ST_FUNCTION; idle = 1'b1;
               end else if (b != 8'd16 && len != 16'd6) begin
                  evt_valid = 1'b1; r.status = ST_LENGTH; idle = 1'b1;
               end
            end
            9'd8, 9'd9: st = {st[7:0], b};
            9'd10: if (func == 8'd5 || func == 8'd6) hold = b;
               else cnt = {cnt[7:0], b};
            9'd11: begin
               if (func == 8'd5 || func == 8'd6) begin
                  evt_valid = 1'b1; idle = 1'b1;
                  r.byte_count = 8'd2; r.value_word = {hold, b};
               end else begin
                  cnt = {cnt[7:0], b};
                  if (func != 8'd16) begin
                     n16 = cnt;
                     pdu = (func <= 8'd2) ? 18'd2 + 18'((17'(n16) + 17'd7) >> 3)
                                          : 18'd2 + {1'b0, n16, 1'b0};
                     evt_valid = 1'b1; idle = 1'b1;
                     if (pdu > 18'(max_pdu_bytes)) r.status = ST_ITEMS;
                  end
               end
            end
            9'd12: begin
               bytes = b;
               if ({9'd0, b} != {cnt, 1'b0}) begin
                  evt_valid = 1'b1; r.status = ST_BYTES; idle = 1'b1;
               end else if (len != 16'd7 + 16'(b)) begin
                  evt_valid = 1'b1; r.status = ST_LENGTH; idle = 1'b1;
               end else if (b == 8'd0) begin
                  evt_valid = 1'b1; idle = 1'b1;
               end
            end
            default: begin
               if (pos[0]) hold = b;   // even offset from 13: high byte
               else begin
                  evt_valid = 1'b1;
                  r.kind = 1'b0; r.last = 1'b0;
                  r.byte_count = bytes; r.value_word = {hold, b};
                  if ((pos - 9'd12) >= 9'(bytes)) begin
                     idle = 1'b1;
                     evt.two = 1'b1;
                  end
               end
            end
         endcase
         r.transaction_id = trn; r.unit_addr = unit; r.function_code = func;
         r.start_item = st; r.item_count = cnt;
         evt.first = r;
         evt.second = r;
         evt.second.kind = 1'b1; evt.second.last = 1'b1; evt.second.value_word = '0;
         evt_valid = evt_valid & in_fire;
      end
      idle_in = idle; trn_in = trn; len_in = len; start_in = st; cnt_in = cnt;
      unit_in = unit; func_in = func; bytes_in = bytes; hold_in = hold;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; idle_ff <= 1'b1; trn_ff <= '0; len_ff <= '0; start_ff <= '0;
         cnt_ff <= '0; unit_ff <= '0; func_ff <= '0; bytes_ff <= '0; hold_ff <= '0;
      end else if (in_fire) begin
         pos_ff <= pos_in; idle_ff <= idle_in; trn_ff <= trn_in; len_ff <= len_in;
         start_ff <= start_in; cnt_ff <= cnt_in; unit_ff <= unit_in;
         func_ff <= func_in; bytes_ff <= bytes_in; hold_ff <= hold_in;
      end
   end

endmodule

// File: rtl/core/mbtcp_queue.sv
`timescale 1ns / 1ps
module mbtcp_queue
   import mbtcp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  evt_type wr_data,
   output logic    full,
   output logic    empty,
   input  logic    rd_en,
   output evt_type rd_data
);

   evt_type    mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;

   assign full    = cnt_ff >= 3'd3;   // one slack entry for the request in flight
   assign empty   = cnt_ff == 3'd0;
   assign rd_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wp_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (wr_en) wp_ff <= wp_ff + 2'd1;
         if (rd_en) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(wr_en) - 3'(rd_en);
      end
   end

endmodule

// File: rtl/core/mbtcp_back.sv
`timescale 1ns / 1ps
module mbtcp_back
   import mbtcp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            q_empty,
   input  evt_type         q_data,
   output logic            q_pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   logic sec_ff, sec_in;

   assign rsp_valid = !q_empty;
   assign rsp_data  = sec_ff ? q_data.second : q_data.first;

   always_comb begin
      sec_in = sec_ff;
      q_pop  = 1'b0;
      if (rsp_valid && !rsp_stall) begin
         if (q_data.two && !sec_ff) sec_in = 1'b1;
         else begin
            sec_in = 1'b0;
            q_pop  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) sec_ff <= 1'b0;
      else sec_ff <= sec_in;
   end

endmodule

// File: test/tb_modbus_tcp_request_parser.sv
`timescale 1ns / 1ps
module tb_modbus_tcp_request_parser;
   import mbtcp_pkg::*;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_data;
   logic            csr_valid;
   logic            csr_ready;
   logic [1:0]      csr_index;
   logic [15:0]     csr_data;

   modbus_tcp_request_parser u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // parser model state
   logic [15:0] cfg_proto;
   logic [7:0]  cfg_min_unit;
   logic [7:0]  cfg_max_unit;
   logic [8:0]  cfg_max_pdu;
   logic [8:0]  pos_q;
   logic        idle_q;
   logic [15:0] tid_q, len_q, start_q, count_q;
   logic [7:0]  unit_q, func_q, bytes_q, hold_q;

   req_payload_type  byte_queue[$];
   rsp_payload_type  expected_rsp[$];
   int  errors;
   bit  hold_off;
   int  hold_cycles;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic rsp_payload_type make_rsp(logic k, logic [7:0] bc,
         logic [15:0] val, logic [2:0] st, logic lst);
      rsp_payload_type r;
      r.kind = k; r.transaction_id = tid_q; r.unit_addr = unit_q;
      r.function_code = func_q; r.start_item = start_q;
      r.item_count = count_q; r.byte_count = bc; r.value_word = val;
      r.status = st; r.last = lst;
      return r;
   endfunction

   task automatic parse_fail(logic [2:0] st);
      idle_q = 1;
      expected_rsp.push_back(make_rsp(1, 0, 0, st, 1));
   endtask

   task automatic predict_byte(req_payload_type it);
      logic [7:0] b;
      int unsigned p, n, pdu;
      logic [7:0] fc;
      b = it.rx_byte;
      if (it.frame_start) begin
         pos_q = 0; tid_q = 0; len_q = 0; unit_q = 0; func_q = 0;
         start_q = 0; count_q = 0; bytes_q = 0; hold_q = 0; idle_q = 0;
      end
      if (idle_q) return;
      p = pos_q;
      if (pos_q != 9'h1FF) pos_q = pos_q + 1;
      fc = func_q;
      case (p)
         0, 1: tid_q = {tid_q[7:0], b};
         2: hold_q = b;
         3: if ({hold_q, b} != cfg_proto) parse_fail(ST_PROTOCOL);
         4, 5: len_q = {len_q[7:0], b};
         6: begin
            unit_q = b;
            if (b < cfg_min_unit || b > cfg_max_unit) parse_fail(ST_ADDRESS);
         end
         7: begin
            func_q = b;
            if (!((b >= 1 && b <= 6) || b == 16)) parse_fail(ST_FUNCTION);
            else if (b != 16 && len_q != 6) parse_fail(ST_LENGTH);
         end
         8, 9: start_q = {start_q[7:0], b};
         10: if (fc == 5 || fc == 6) hold_q = b; else count_q = {count_q[7:0], b};
         11: begin
            if (fc == 5 || fc == 6) begin
               idle_q = 1;
               expected_rsp.push_back(make_rsp(1, 2, {hold_q, b}, ST_OK, 1));
            end else begin
               count_q = {count_q[7:0], b};
               if (fc != 16) begin
                  n = count_q;
                  pdu = (fc <= 2) ? 2 + (n + 7) / 8 : 2 + n * 2;
                  if (pdu > cfg_max_pdu) parse_fail(ST_ITEMS);
                  else begin
                     idle_q = 1;
                     expected_rsp.push_back(make_rsp(1, 0, 0, ST_OK, 1));
                  end
               end
            end
         end
         12: begin
            bytes_q = b;
            if (32'(b) != 32'(count_q) * 2) parse_fail(ST_BYTES);
            else if (32'(len_q) != 7 + 32'(b)) parse_fail(ST_LENGTH);
            else if (b == 0) begin
               idle_q = 1;
               expected_rsp.push_back(make_rsp(1, 0, 0, ST_OK, 1));
            end
         end
         default: begin
            if (((p - 13) & 1) == 0) hold_q = b;
            else begin
               expected_rsp.push_back(make_rsp(0, bytes_q, {hold_q, b}, ST_OK, 0));
               if (p - 12 >= bytes_q) begin
                  idle_q = 1;
                  expected_rsp.push_back(make_rsp(1, bytes_q, 0, ST_OK, 1));
               end
            end
         end
      endcase
   endtask

   // capture the handshakes at the rising edge
   logic req_stall_s;
   logic rsp_fire_s;
   always @(posedge clock) req_stall_s <= req_stall;
   always @(posedge clock) rsp_fire_s <= rsp_valid && !rsp_stall;

   // driver: one byte from the queue at a time, sometimes back to back, else after a random gap
   int gap_left;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 0;
         gap_left <= $urandom_range(0, 7);
      end else if (req_valid && !req_stall_s) begin
         // accepted at the last rising edge
         predict_byte(req_data);
         void'(byte_queue.pop_front());
         if (byte_queue.size() != 0 && $urandom_range(0, 1) == 0) begin
            req_data <= byte_queue[0];
            gap_left <= 0;
         end else begin
            req_valid <= 0;
            gap_left <= $urandom_range(0, 7);
         end
      end else if (!req_valid) begin
         if (gap_left > 0) gap_left <= gap_left - 1;
         else if (byte_queue.size() != 0) begin
            req_valid <= 1;
            req_data <= byte_queue[0];
         end
      end
   end

   // result side: random stall after each result, plus a long hold-off on request
   int stall_left;
   always @(negedge clock) begin
      int draw;
      if (reset) begin
         rsp_stall <= 1;
         stall_left <= 0;
      end else if (hold_off) begin
         rsp_stall <= 1;
      end else if (rsp_fire_s) begin
         draw = $urandom_range(0, 7);
         if (draw > 0) begin
            stall_left <= draw - 1;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
         end
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   always @(posedge clock) begin
      rsp_payload_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected result %p", rsp_data);
            errors++;
         end else begin
            e = expected_rsp.pop_front();
            if (rsp_data.kind != e.kind) begin
               $error("kind exp %0h got %0h", e.kind, rsp_data.kind); errors++; end
            if (rsp_data.transaction_id != e.transaction_id) begin
               $error("transaction_id exp %0h got %0h", e.transaction_id,
                      rsp_data.transaction_id); errors++; end
            if (rsp_data.unit_addr != e.unit_addr) begin
               $error("unit_addr exp %0h got %0h", e.unit_addr, rsp_data.unit_addr);
               errors++; end
            if (rsp_data.function_code != e.function_code) begin
               $error("function_code exp %0h got %0h", e.function_code,
                      rsp_data.function_code); errors++; end
            if (rsp_data.start_item != e.start_item) begin
               $error("start_item exp %0h got %0h", e.start_item, rsp_data.start_item);
               errors++; end
            if (rsp_data.item_count != e.item_count) begin
               $error("item_count exp %0h got %0h", e.item_count, rsp_data.item_count);
               errors++; end
            if (rsp_data.byte_count != e.byte_count) begin
               $error("byte_count exp %0h got %0h", e.byte_count, rsp_data.byte_count);
               errors++; end
            if (rsp_data.value_word != e.value_word) begin
               $error("value_word exp %0h got %0h", e.value_word, rsp_data.value_word);
               errors++; end
            if (rsp_data.status != e.status) begin
               $error("status exp %0h got %0h", e.status, rsp_data.status); errors++; end
            if (rsp_data.last != e.last) begin
               $error("last exp %0h got %0h", e.last, rsp_data.last); errors++; end
         end
      end
   end

   task automatic push_byte(logic [7:0] b, logic s);
      req_payload_type it;
      it.rx_byte = b; it.frame_start = s;
      byte_queue.push_back(it);
   endtask

   task automatic push_frame(logic [15:0] tid, logic [15:0] proto, logic [15:0] len,
         logic [7:0] unit, logic [7:0] fc, logic [15:0] start, logic [15:0] qty,
         logic [7:0] bc, int ndata, int cut);
      logic [7:0] fr[$];
      fr = {tid[15:8], tid[7:0], proto[15:8], proto[7:0], len[15:8], len[7:0],
            unit, fc, start[15:8], start[7:0], qty[15:8], qty[7:0]};
      if (fc == 16) begin
         fr.push_back(bc);
         repeat (ndata) fr.push_back(8'($urandom));
      end
      if (cut > 0 && cut < fr.size()) fr = fr[0:cut-1];
      foreach (fr[i]) push_byte(fr[i], i == 0);
   endtask

   task automatic wait_drain();
      while (byte_queue.size() != 0 || req_valid) @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_PROTOCOL: cfg_proto = val;
         CSR_MIN_UNIT: cfg_min_unit = val[7:0];
         CSR_MAX_UNIT: cfg_max_unit = val[7:0];
         CSR_MAX_PDU:  cfg_max_pdu = val[8:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic random_frame();
      logic [7:0] fc, unit, bc;
      logic [15:0] qty, len, proto;
      int k, nd, cut;
      k = $urandom_range(0, 9);
      fc = (k < 2) ? 16 : (k < 8) ? 8'($urandom_range(1, 6)) : 8'($urandom);
      unit = ($urandom_range(0, 7) == 0) ? 8'($urandom)
             : 8'($urandom_range(cfg_min_unit, cfg_max_unit));
      proto = ($urandom_range(0, 15) == 0) ? 16'($urandom) : cfg_proto;
      qty = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 130));
      if (fc == 16) begin
         qty = $urandom_range(0, 4);
         bc = 8'(qty * 2);
         if ($urandom_range(0, 7) == 0) bc = 8'($urandom);
         nd = bc;
         len = 7 + bc;
      end else begin
         bc = 0; nd = 0; len = 6;
      end
      if ($urandom_range(0, 11) == 0) len = 16'($urandom);
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 14) : 0;
      push_frame(16'($urandom), proto, len, unit, fc, 16'($urandom), qty, bc, nd, cut);
      if ($urandom_range(0, 9) == 0) push_byte(8'($urandom), 0);
   endtask

   initial begin
      errors = 0; hold_off = 0;
      req_valid = 0; req_data = '0; rsp_stall = 1;
      csr_valid = 0; csr_index = CSR_PROTOCOL; csr_data = 0;
      cfg_proto = 0; cfg_min_unit = 1; cfg_max_unit = 247; cfg_max_pdu = 253;
      pos_q = 0; idle_q = 1; tid_q = 0; len_q = 0; unit_q = 0; func_q = 0;
      start_q = 0; count_q = 0; bytes_q = 0; hold_q = 0;
      reset = 1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed frames at reset config
      push_byte(8'hFF, 0);                       // idle byte, ignored
      push_frame(16'hFFFF, 0, 6, 1, 3, 16'hFFFF, 125, 0, 0, 0);
      push_frame(16'h0000, 0, 6, 247, 1, 0, 16'hFFFF, 0, 0, 0);
      push_frame(16'h1234, 0, 6, 5, 2, 0, 2000, 0, 0, 0);
      push_frame(16'h1, 0, 6, 5, 4, 0, 126, 0, 0, 0);
      push_frame(16'h2, 0, 6, 5, 5, 16'h55, 16'hFF00, 0, 0, 0);
      push_frame(16'h3, 0, 6, 5, 5, 16'h55, 16'h1234, 0, 0, 0);
      push_frame(16'h4, 0, 6, 5, 6, 16'hAA, 16'hFFFF, 0, 0, 0);
      push_frame(16'h5, 0, 11, 5, 16, 7, 2, 4, 4, 0);
      push_frame(16'h6, 0, 7, 5, 16, 7, 0, 0, 0, 0);
      push_frame(16'h7, 0, 11, 5, 16, 7, 2, 5, 0, 0);
      push_frame(16'h8, 0, 12, 5, 16, 7, 2, 4, 0, 0);
      push_frame(16'h9, 16'h0001, 6, 5, 3, 0, 1, 0, 0, 0);
      push_frame(16'hA, 0, 6, 0, 3, 0, 1, 0, 0, 0);
      push_frame(16'hB, 0, 6, 248, 3, 0, 1, 0, 0, 0);
      push_frame(16'hC, 0, 6, 5, 7, 0, 1, 0, 0, 0);
      push_frame(16'hD, 0, 5, 5, 3, 0, 1, 0, 0, 0);
      push_frame(16'hE, 0, 6, 5, 3, 0, 1, 0, 0, 6);  // restart mid-frame
      push_frame(16'hF, 0, 6, 5, 3, 0, 1, 0, 0, 0);
      wait_drain();

      // long receiver hold-off while the sender keeps going
      repeat (16) random_frame();
      hold_off = 1;
      hold_cycles = 0;
      while (hold_cycles < 300) begin
         @(posedge clock);
         hold_cycles++;
      end
      hold_off = 0;
      wait_drain();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin write_csr(CSR_PROTOCOL, 16'hFFFF); write_csr(CSR_MIN_UNIT, 0);
               write_csr(CSR_MAX_UNIT, 255); write_csr(CSR_MAX_PDU, 0); end
            1: begin write_csr(CSR_PROTOCOL, 16'h0000); write_csr(CSR_MAX_PDU, 511);
               write_csr(CSR_MIN_UNIT, 255); end
            2: begin write_csr(CSR_PROTOCOL, 16'($urandom));
               write_csr(CSR_MIN_UNIT, 16'($urandom_range(0, 100)));
               write_csr(CSR_MAX_UNIT, 16'($urandom_range(100, 255)));
               write_csr(CSR_MAX_PDU, 16'($urandom_range(0, 511))); end
            3: begin write_csr(CSR_MIN_UNIT, 10); write_csr(CSR_MAX_UNIT, 5); end
            default: begin write_csr(CSR_PROTOCOL, 0); write_csr(CSR_MIN_UNIT, 1);
               write_csr(CSR_MAX_UNIT, 247); write_csr(CSR_MAX_PDU, 253); end
         endcase
         repeat (3) random_frame();
         wait_drain();
      end
      repeat (3) random_frame();
      wait_drain();

      if (errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule

// File: filelist.f
rtl/core/mbtcp_pkg.sv
rtl/core/mbtcp_front.sv
rtl/core/mbtcp_queue.sv
rtl/core/mbtcp_back.sv
rtl/core/modbus_tcp_request_parser.sv
test/tb_modbus_tcp_request_parser.sv
